>>> src/ccedc_pkg.sv
// ----------------------------------------------------------------------------
// ccedc_pkg
// Shared types and constants of the cyclic code error detection check block.
// ----------------------------------------------------------------------------
package ccedc_pkg;

    // field widths of the request and result items
    localparam int CODE_W  = 31;
    localparam int SYN_W   = 15;
    localparam int COUNT_W = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam int CFG_REG_W  = 16;

    localparam logic [REG_IDX_W-1:0] REG_GEN_POLY = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_MESSAGE  = 1'b1;

    localparam logic [CFG_REG_W-1:0] GEN_POLY_RST = 16'd11;
    localparam logic [CFG_REG_W-1:0] MESSAGE_RST  = 16'd1;

    // per-step control shared by every cell of a division chain
    typedef struct packed {
        logic clr;
        logic step;
    } ccedc_ctrl_t;

endpackage

>>> src/ccedc_if.sv
// ----------------------------------------------------------------------------
// ccedc request and result channels
// Valid/ready channels carrying one trial request and one trial result.
// ----------------------------------------------------------------------------
interface ccedc_in_if;
    import ccedc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] error_pattern;
    logic              clear_count;

    modport source (output valid, output error_pattern, output clear_count, input ready);
    modport sink   (input valid, input error_pattern, input clear_count, output ready);
endinterface

interface ccedc_out_if;
    import ccedc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  codeword;
    logic [SYN_W-1:0]   syndrome;
    logic               error_present;
    logic               undetected;
    logic [COUNT_W-1:0] undetected_count;

    modport source (
        output valid, output codeword, output syndrome, output error_present,
        output undetected, output undetected_count, input ready
    );
    modport sink (
        input valid, input codeword, input syndrome, input error_present,
        input undetected, input undetected_count, output ready
    );
endinterface

>>> src/ccedc_cell.sv
// ----------------------------------------------------------------------------
// ccedc_cell
// One remainder bit of a bit-serial GF(2) divider: takes its neighbour's bit
// and folds in the generator coefficient when the feedback is set.
// ----------------------------------------------------------------------------
module ccedc_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccedc_pkg::ccedc_ctrl_t ctrl,
    input  logic                   shift_in,
    input  logic                   fb,
    input  logic                   gen_bit,
    output logic                   q
);
    import ccedc_pkg::*;

    logic q_reg;
    logic q_next;

    // shift from neighbour, subtract generator term on feedback
    always_comb
    begin
        q_next = q_reg;
        if (ctrl.clr)
        begin
            q_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            q_next = shift_in ^ (fb & gen_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> src/ccedc_divider.sv
// ----------------------------------------------------------------------------
// ccedc_divider
// Row of remainder cells dividing a serial bit stream, MSB first, by a
// generator of run-time degree.
// ----------------------------------------------------------------------------
module ccedc_divider #(
    parameter int REM_W = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ccedc_pkg::ccedc_ctrl_t         ctrl,
    input  logic                           din,
    input  logic [REM_W-1:0]               gen,
    input  logic [$clog2(REM_W+1)-1:0]     deg,
    output logic [REM_W-1:0]               rem
);
    import ccedc_pkg::*;

    logic [REM_W:0] shifted;
    logic           fb;

    // remainder shifted up with the new bit at the bottom
    assign shifted = {rem, din};

    // the bit reaching the generator degree decides the subtraction
    assign fb = shifted[deg];

    // chain of cells
    for (genvar k = 0; k < REM_W; k++)
    begin : g_cell
        ccedc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .shift_in (shifted[k]),
            .fb       (fb),
            .gen_bit  (gen[k]),
            .q        (rem[k])
        );
    end

endmodule

>>> src/cyclic_code_error_detection_check_top.sv
// ----------------------------------------------------------------------------
// cyclic_code_error_detection_check_top
// Takes one request at a time: the request port is ready only while idle, so a
// new request is accepted only after the previous result has been loaded. Each
// request passes through the bit-serial division chains (one codeword bit per
// cycle) and then the result load, which waits while an unread result is held.
// rst_n (asynchronous, active low) clears the sequencer, result valid and miss
// count and restores the generator to 11 and the message to 1; no clearing pass.
// ----------------------------------------------------------------------------
module cyclic_code_error_detection_check_top #(
    parameter int GEN_BITS = 16,
    parameter int MSG_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ccedc_in_if.sink                           in_ch,
    ccedc_out_if.source                        out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ccedc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ccedc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ccedc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import ccedc_pkg::*;

    // effective widths: the registers never hold more than 16 bits
    localparam int G_W    = (GEN_BITS < CFG_REG_W) ? GEN_BITS : CFG_REG_W;
    localparam int M_W    = (MSG_BITS < CFG_REG_W) ? MSG_BITS : CFG_REG_W;
    localparam int REM_W  = G_W - 1;
    localparam int CW     = M_W + G_W - 1;
    localparam int DEG_W  = $clog2(REM_W + 1);
    localparam int ML_W   = $clog2(M_W + 1);
    localparam int NL_W   = $clog2(CW + 1);
    localparam int STEP_W = $clog2(CW);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [CW-1:0]          a_data_reg, a_data_next;
    logic [CW-1:0]          b_data_reg, b_data_next;
    logic                   present_reg, present_next;
    logic                   clear_reg, clear_next;
    logic [CFG_REG_W-1:0]   gen_poly_reg, gen_poly_next;
    logic [CFG_REG_W-1:0]   message_reg, message_next;
    logic [COUNT_W-1:0]     miss_count_reg, miss_count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]      out_code_reg, out_code_next;
    logic [SYN_W-1:0]       out_syn_reg, out_syn_next;
    logic                   out_present_reg, out_present_next;
    logic                   out_miss_reg, out_miss_next;

    logic [G_W-1:0]         g;
    logic [M_W-1:0]         m;
    logic [DEG_W-1:0]       deg;
    logic [ML_W-1:0]        mlen;
    logic [NL_W-1:0]        n_len;
    logic [CW-1:0]          shifted;
    logic [CW-1:0]          nmask;
    logic [CW-1:0]          err_masked;
    logic                   g_small;
    logic                   in_take;
    logic                   out_load;
    ccedc_ctrl_t            div_ctrl;
    logic [REM_W-1:0]       rem_a;
    logic [REM_W-1:0]       rem_b;
    logic [REM_W-1:0]       syn;
    logic [CW-1:0]          code;
    logic                   missed;
    logic [COUNT_W-1:0]     count_base;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   reg_idx;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        gen_poly_next = gen_poly_reg;
        message_next  = message_reg;
        if (cfg_wr && (reg_idx == REG_GEN_POLY))
        begin
            gen_poly_next = pwdata[CFG_REG_W-1:0];
        end
        if (cfg_wr && (reg_idx == REG_MESSAGE))
        begin
            message_next = pwdata[CFG_REG_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_idx == REG_GEN_POLY)
        begin
            prdata = APB_DATA_W'(gen_poly_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(message_reg);
        end
    end

    // code geometry from the configured polynomials
    assign g       = gen_poly_reg[G_W-1:0];
    assign m       = message_reg[M_W-1:0];
    assign g_small = (g[G_W-1:1] == '0);

    always_comb
    begin
        deg  = '0;
        mlen = '0;
        for (int i = 1; i < G_W; i++)
        begin
            if (g[i])
            begin
                deg = DEG_W'(i);
            end
        end
        for (int i = 0; i < M_W; i++)
        begin
            if (m[i])
            begin
                mlen = ML_W'(i + 1);
            end
        end
    end

    assign n_len   = NL_W'(mlen) + NL_W'(deg);
    assign shifted = CW'(m) << deg;

    always_comb
    begin
        for (int i = 0; i < CW; i++)
        begin
            nmask[i] = (NL_W'(i) < n_len);
        end
    end

    assign err_masked = in_ch.error_pattern[CW-1:0] & nmask;

    // handshakes
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        a_data_next  = a_data_reg;
        b_data_next  = b_data_reg;
        present_next = present_reg;
        clear_next   = clear_reg;
        div_ctrl     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next   = ST_RUN;
                    step_next    = STEP_W'(CW - 1);
                    a_data_next  = shifted;
                    b_data_next  = shifted ^ err_masked;
                    present_next = (err_masked != '0);
                    clear_next   = in_ch.clear_count;
                    div_ctrl.clr = 1'b1;
                end
            end
            ST_RUN:
            begin
                div_ctrl.step = 1'b1;
                a_data_next   = a_data_reg << 1;
                b_data_next   = b_data_reg << 1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // message remainder chain and received word remainder chain
    ccedc_divider #(
        .REM_W (REM_W)
    ) u_div_code (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .din   (a_data_reg[CW-1]),
        .gen   (g[REM_W-1:0]),
        .deg   (deg),
        .rem   (rem_a)
    );

    ccedc_divider #(
        .REM_W (REM_W)
    ) u_div_recv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .din   (b_data_reg[CW-1]),
        .gen   (g[REM_W-1:0]),
        .deg   (deg),
        .rem   (rem_b)
    );

    // result: by linearity the syndrome is the difference of the two remainders
    assign syn    = g_small ? '0 : (rem_a ^ rem_b);
    assign code   = g_small ? shifted : (shifted | CW'(rem_a));
    assign missed = present_reg && (syn == '0);

    // saturating miss count and result register
    always_comb
    begin
        count_base       = clear_reg ? '0 : miss_count_reg;
        miss_count_next  = miss_count_reg;
        out_valid_next   = out_valid_reg;
        out_code_next    = out_code_reg;
        out_syn_next     = out_syn_reg;
        out_present_next = out_present_reg;
        out_miss_next    = out_miss_reg;
        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            miss_count_next = count_base;
            if (missed && (count_base != '1))
            begin
                miss_count_next = count_base + 1'b1;
            end
            out_valid_next   = 1'b1;
            out_code_next    = CODE_W'(code);
            out_syn_next     = SYN_W'(syn);
            out_present_next = present_reg;
            out_miss_next    = missed;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            gen_poly_reg   <= GEN_POLY_RST;
            message_reg    <= MESSAGE_RST;
            miss_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            gen_poly_reg   <= gen_poly_next;
            message_reg    <= message_next;
            miss_count_reg <= miss_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_data_reg      <= a_data_next;
        b_data_reg      <= b_data_next;
        present_reg     <= present_next;
        clear_reg       <= clear_next;
        out_code_reg    <= out_code_next;
        out_syn_reg     <= out_syn_next;
        out_present_reg <= out_present_next;
        out_miss_reg    <= out_miss_next;
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.codeword         = out_code_reg;
    assign out_ch.syndrome         = out_syn_reg;
    assign out_ch.error_present    = out_present_reg;
    assign out_ch.undetected       = out_miss_reg;
    assign out_ch.undetected_count = miss_count_reg;

    // a taken request always starts the division run
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_RUN))
        else $error("request taken but division did not start");

    // an undetected error needs a nonzero pattern
    a_miss_needs_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.undetected) |-> out_ch.error_present)
        else $error("undetected flagged without an error");

    // an undetected error needs a zero syndrome
    a_miss_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.undetected) |-> (out_ch.syndrome == '0))
        else $error("undetected flagged with nonzero syndrome");

    // a miss leaves the count above zero
    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.undetected) |-> (out_ch.undetected_count != '0))
        else $error("miss not counted");

endmodule
